@@ src/nec_ir_frame_decoder_unit_defines.svh @@
// assertion macros for the nec ir frame decoder
// used by the checker module; no other dependencies
`ifndef NEC_IR_FRAME_DECODER_UNIT_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define NECIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("necir check failed");

// next-cycle implication, disabled while in reset
`define NECIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("necir check failed");

`endif

@@ src/necir_pkg.sv @@
// shared types and constants for the nec ir frame decoder
// no dependencies; used by every other file of the block but the defines header
package necir_pkg;

	localparam int DURATION_WIDTH_DEF = 16;
	localparam int FRAME_BITS_DEF     = 32;
	localparam int CFG_W              = 16;
	localparam int CFG_IDX_W          = 4;
	localparam int STATUS_W           = 3;
	localparam int FRAME_W            = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MIN  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MAX  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MAX = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE_MIN  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE_MAX  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_MIN    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_MAX    = 4'd7;

	localparam logic [CFG_W-1:0] RST_LEADER_MARK_MIN  = 16'd2700;
	localparam logic [CFG_W-1:0] RST_LEADER_MARK_MAX  = 16'd2850;
	localparam logic [CFG_W-1:0] RST_LEADER_SPACE_MIN = 16'd1350;
	localparam logic [CFG_W-1:0] RST_LEADER_SPACE_MAX = 16'd1450;
	localparam logic [CFG_W-1:0] RST_SHORT_PULSE_MIN  = 16'd160;
	localparam logic [CFG_W-1:0] RST_SHORT_PULSE_MAX  = 16'd190;
	localparam logic [CFG_W-1:0] RST_ONE_SPACE_MIN    = 16'd490;
	localparam logic [CFG_W-1:0] RST_ONE_SPACE_MAX    = 16'd560;

	localparam logic [STATUS_W-1:0] STATUS_OK               = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_LEADER_MARK  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_LEADER_SPACE = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_BIT_MARK     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_BAD_BIT_SPACE    = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LSPACE = 3'd1,
		PH_BMARK  = 3'd2,
		PH_BSPACE = 3'd3,
		PH_STOP   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] leader_mark_min;
		logic [CFG_W-1:0] leader_mark_max;
		logic [CFG_W-1:0] leader_space_min;
		logic [CFG_W-1:0] leader_space_max;
		logic [CFG_W-1:0] short_pulse_min;
		logic [CFG_W-1:0] short_pulse_max;
		logic [CFG_W-1:0] one_space_min;
		logic [CFG_W-1:0] one_space_max;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  bits;
	} result_t;

endpackage

@@ src/necir_ifs.sv @@
// channel interfaces of the nec ir frame decoder: pulses in, frames out, register writes
// depends on necir_pkg
interface necir_pulse_if #(
	parameter int DURATION_WIDTH = necir_pkg::DURATION_WIDTH_DEF
);
	logic                      valid;
	logic                      ready;
	logic                      is_mark;
	logic [DURATION_WIDTH-1:0] duration;

	modport source (output valid, is_mark, duration, input ready);
	modport sink (input valid, is_mark, duration, output ready);
endinterface

interface necir_frame_if;
	logic                          valid;
	logic                          ready;
	logic [necir_pkg::STATUS_W-1:0] status;
	logic [7:0]                    addr_byte;
	logic [7:0]                    addr_inv_byte;
	logic [7:0]                    cmd_byte;
	logic [7:0]                    cmd_inv_byte;

	modport source (output valid, status, addr_byte, addr_inv_byte, cmd_byte, cmd_inv_byte,
		input ready);
	modport sink (input valid, status, addr_byte, addr_inv_byte, cmd_byte, cmd_inv_byte,
		output ready);
endinterface

interface necir_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [necir_pkg::CFG_IDX_W-1:0] index;
	logic [necir_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/necir_cfg_regs.sv @@
// timing window registers, written through the configuration channel
// depends on necir_pkg and necir_cfg_if
module necir_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	necir_cfg_if.sink         cfg,
	output necir_pkg::cfg_t   regs
);

	necir_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.leader_mark_min  <= necir_pkg::RST_LEADER_MARK_MIN;
			regs_q.leader_mark_max  <= necir_pkg::RST_LEADER_MARK_MAX;
			regs_q.leader_space_min <= necir_pkg::RST_LEADER_SPACE_MIN;
			regs_q.leader_space_max <= necir_pkg::RST_LEADER_SPACE_MAX;
			regs_q.short_pulse_min  <= necir_pkg::RST_SHORT_PULSE_MIN;
			regs_q.short_pulse_max  <= necir_pkg::RST_SHORT_PULSE_MAX;
			regs_q.one_space_min    <= necir_pkg::RST_ONE_SPACE_MIN;
			regs_q.one_space_max    <= necir_pkg::RST_ONE_SPACE_MAX;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				necir_pkg::REG_LEADER_MARK_MIN:  regs_q.leader_mark_min  <= cfg.data;
				necir_pkg::REG_LEADER_MARK_MAX:  regs_q.leader_mark_max  <= cfg.data;
				necir_pkg::REG_LEADER_SPACE_MIN: regs_q.leader_space_min <= cfg.data;
				necir_pkg::REG_LEADER_SPACE_MAX: regs_q.leader_space_max <= cfg.data;
				necir_pkg::REG_SHORT_PULSE_MIN:  regs_q.short_pulse_min  <= cfg.data;
				necir_pkg::REG_SHORT_PULSE_MAX:  regs_q.short_pulse_max  <= cfg.data;
				necir_pkg::REG_ONE_SPACE_MIN:    regs_q.one_space_min    <= cfg.data;
				necir_pkg::REG_ONE_SPACE_MAX:    regs_q.one_space_max    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ src/necir_step.sv @@
// input register and per-pulse frame state machine
// depends on necir_pkg and necir_pulse_if
module necir_step #(
	parameter int DURATION_WIDTH = necir_pkg::DURATION_WIDTH_DEF,
	parameter int FRAME_BITS     = necir_pkg::FRAME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	necir_pulse_if.sink         pulse,
	input  necir_pkg::cfg_t     regs,
	output logic                res_valid,
	input  logic                res_ready,
	output necir_pkg::result_t  res
);

	localparam int CMP_W = (DURATION_WIDTH > necir_pkg::CFG_W) ? DURATION_WIDTH
		: necir_pkg::CFG_W;
	localparam int CNT_W = $clog2(FRAME_BITS);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

	function automatic logic in_win(input logic [CMP_W-1:0] d,
		input logic [necir_pkg::CFG_W-1:0] lo, input logic [necir_pkg::CFG_W-1:0] hi);
		return (d > CMP_W'(lo)) && (d < CMP_W'(hi));
	endfunction

	logic                      valid_s1;
	logic                      is_mark_s1;
	logic [DURATION_WIDTH-1:0] duration_s1;

	necir_pkg::phase_t     phase_q, phase_n;
	logic [CNT_W-1:0]      bit_cnt_q, bit_cnt_n;
	logic [FRAME_BITS-1:0] shift_q, shift_n, shift_in;

	logic [CMP_W-1:0] dur;
	logic             win_lmark, win_lspace, win_short, win_one;
	logic             advance;

	assign dur        = CMP_W'(duration_s1);
	assign win_lmark  = in_win(dur, regs.leader_mark_min, regs.leader_mark_max);
	assign win_lspace = in_win(dur, regs.leader_space_min, regs.leader_space_max);
	assign win_short  = in_win(dur, regs.short_pulse_min, regs.short_pulse_max);
	assign win_one    = in_win(dur, regs.one_space_min, regs.one_space_max);
	assign shift_in   = {win_one & ~win_short, shift_q[FRAME_BITS-1:1]};

	always_comb begin
		phase_n    = phase_q;
		bit_cnt_n  = bit_cnt_q;
		shift_n    = shift_q;
		res_valid  = 1'b0;
		res.status = necir_pkg::STATUS_OK;
		res.bits   = '0;
		if (valid_s1) begin
			unique case (phase_q)
				necir_pkg::PH_LSPACE: begin
					phase_n   = necir_pkg::PH_BMARK;
					bit_cnt_n = '0;
					shift_n   = '0;
					if (is_mark_s1 || !win_lspace) begin
						phase_n    = necir_pkg::PH_IDLE;
						res_valid  = 1'b1;
						res.status = necir_pkg::STATUS_BAD_LEADER_SPACE;
					end
				end
				necir_pkg::PH_BMARK: begin
					if (!is_mark_s1 || !win_short) begin
						phase_n    = necir_pkg::PH_IDLE;
						bit_cnt_n  = '0;
						shift_n    = '0;
						res_valid  = 1'b1;
						res.status = necir_pkg::STATUS_BAD_BIT_MARK;
					end else begin
						phase_n = necir_pkg::PH_BSPACE;
					end
				end
				necir_pkg::PH_BSPACE: begin
					if (is_mark_s1 || !(win_short || win_one)) begin
						phase_n    = necir_pkg::PH_IDLE;
						bit_cnt_n  = '0;
						shift_n    = '0;
						res_valid  = 1'b1;
						res.status = necir_pkg::STATUS_BAD_BIT_SPACE;
					end else if (bit_cnt_q == LAST_BIT) begin
						phase_n   = necir_pkg::PH_STOP;
						bit_cnt_n = '0;
						shift_n   = '0;
						res_valid = 1'b1;
						res.bits  = necir_pkg::FRAME_W'(shift_in);
					end else begin
						phase_n   = necir_pkg::PH_BMARK;
						bit_cnt_n = bit_cnt_q + CNT_W'(1);
						shift_n   = shift_in;
					end
				end
				necir_pkg::PH_STOP: begin
					phase_n   = necir_pkg::PH_IDLE;
					bit_cnt_n = '0;
					shift_n   = '0;
				end
				default: begin
					phase_n   = necir_pkg::PH_IDLE;
					bit_cnt_n = '0;
					shift_n   = '0;
					if (is_mark_s1) begin
						if (win_lmark) begin
							phase_n = necir_pkg::PH_LSPACE;
						end else begin
							res_valid  = 1'b1;
							res.status = necir_pkg::STATUS_BAD_LEADER_MARK;
						end
					end
				end
			endcase
		end
	end

	assign advance     = valid_s1 && (!res_valid || res_ready);
	assign pulse.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse.ready) begin
			valid_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.valid && pulse.ready) begin
			is_mark_s1  <= pulse.is_mark;
			duration_s1 <= pulse.duration;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= necir_pkg::PH_IDLE;
			bit_cnt_q <= '0;
			shift_q   <= '0;
		end else if (advance) begin
			phase_q   <= phase_n;
			bit_cnt_q <= bit_cnt_n;
			shift_q   <= shift_n;
		end
	end

endmodule

@@ src/necir_out_reg.sv @@
// result register that holds a decoded frame or error until it is taken
// depends on necir_pkg and necir_frame_if
module necir_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	output logic               res_ready,
	input  necir_pkg::result_t res,
	necir_frame_if.source      frame
);

	logic               out_valid_q;
	necir_pkg::result_t out_q;

	assign res_ready = !out_valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.status        = out_q.status;
	assign frame.addr_byte     = out_q.bits[7:0];
	assign frame.addr_inv_byte = out_q.bits[15:8];
	assign frame.cmd_byte      = out_q.bits[23:16];
	assign frame.cmd_inv_byte  = out_q.bits[31:24];

endmodule

@@ src/nec_ir_frame_decoder_unit.sv @@
// NEC infrared frame decoder. Each pulse item (mark or space, duration in ticks) is taken
// into an input register; the frame state machine judges it against the window registers
// in that cycle and, when a frame completes or a pulse falls outside its window, writes
// one frame item (status and four bytes) into the result register. One pulse is accepted
// every clock cycle, save for the only stall: a full result register that frame.ready has
// not yet emptied. A pulse waits in the input register, and its result in the result register.
// Register writes take effect the cycle after they are accepted; cfg.ready is always high.
// Depends on necir_pkg, the channel interfaces, necir_cfg_regs, necir_step, necir_out_reg.
module nec_ir_frame_decoder_unit #(
	parameter int DURATION_WIDTH = necir_pkg::DURATION_WIDTH_DEF,
	parameter int FRAME_BITS     = necir_pkg::FRAME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	necir_pulse_if.sink   pulse,
	necir_frame_if.source frame,
	necir_cfg_if.sink     cfg
);

	necir_pkg::cfg_t    regs;
	necir_pkg::result_t res;
	logic               res_valid;
	logic               res_ready;

	necir_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	necir_step #(
		.DURATION_WIDTH (DURATION_WIDTH),
		.FRAME_BITS     (FRAME_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.pulse     (pulse),
		.regs      (regs),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	necir_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.frame     (frame)
	);

endmodule

@@ src/necir_checker.sv @@
// port-level checks on the frame channel of the nec ir frame decoder, and their bind
// depends on necir_pkg and nec_ir_frame_decoder_unit_defines.svh
`include "nec_ir_frame_decoder_unit_defines.svh"

module necir_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           frame_valid,
	input logic                           frame_ready,
	input logic [necir_pkg::STATUS_W-1:0] frame_status,
	input logic [7:0]                     frame_addr_byte,
	input logic [7:0]                     frame_addr_inv_byte,
	input logic [7:0]                     frame_cmd_byte,
	input logic [7:0]                     frame_cmd_inv_byte
);

	logic bytes_zero;

	assign bytes_zero = (frame_addr_byte == 8'd0) && (frame_addr_inv_byte == 8'd0)
		&& (frame_cmd_byte == 8'd0) && (frame_cmd_inv_byte == 8'd0);

	`NECIR_ASSERT_NEXT(a_stall_hold, clk, arst_n, frame_valid && !frame_ready, frame_valid && $stable(frame_status) && $stable(frame_addr_byte) && $stable(frame_addr_inv_byte) && $stable(frame_cmd_byte) && $stable(frame_cmd_inv_byte))
	`NECIR_ASSERT_NOW(a_error_bytes_zero, clk, arst_n, frame_valid && (frame_status != necir_pkg::STATUS_OK), bytes_zero)
	`NECIR_ASSERT_NOW(a_status_known, clk, arst_n, frame_valid, (frame_status == necir_pkg::STATUS_OK) || (frame_status == necir_pkg::STATUS_BAD_LEADER_MARK) || (frame_status == necir_pkg::STATUS_BAD_LEADER_SPACE) || (frame_status == necir_pkg::STATUS_BAD_BIT_MARK) || (frame_status == necir_pkg::STATUS_BAD_BIT_SPACE))

endmodule

bind nec_ir_frame_decoder_unit necir_checker u_necir_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.frame_valid         (frame.valid),
	.frame_ready         (frame.ready),
	.frame_status        (frame.status),
	.frame_addr_byte     (frame.addr_byte),
	.frame_addr_inv_byte (frame.addr_inv_byte),
	.frame_cmd_byte      (frame.cmd_byte),
	.frame_cmd_inv_byte  (frame.cmd_inv_byte)
);
